// ----- hw/rtl/mpa_pkg.sv -----
`default_nettype none
// ============================================================================
// mpa_pkg: shared types and helpers for the motion proposal arbiter
// Holds the proposal and round snapshot structs, mode and target codes,
// and the signed Q16.16 saturating adder.
// ============================================================================
package mpa_pkg;

    // proposal modes
    localparam logic [1:0] MODE_BASE       = 2'd0;
    localparam logic [1:0] MODE_CORRECTION = 2'd1;
    localparam logic [1:0] MODE_OVERRIDE   = 2'd2;

    // target kinds
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_VELOCITY = 2'd1,
        KIND_POSITION = 2'd2
    } t_kind;

    // one proposal as held in the input register
    typedef struct packed {
        logic               proposal_valid;
        logic [1:0]         mode;
        logic [7:0]         prio;
        logic               is_position;
        logic signed [31:0] velocity;
        logic signed [31:0] position;
        logic               relative;
        logic               last;
    } t_item;

    // round accumulation, also the snapshot handed to the target stage
    typedef struct packed {
        logic               ovr_present;
        logic               ovr_is_position;
        logic signed [31:0] ovr_velocity;
        logic signed [31:0] ovr_position;
        logic               ovr_relative;
        logic               base_present;
        logic signed [31:0] base_velocity;
        logic signed [31:0] corr_sum;
        logic               corr_seen;
    } t_round;

    // signed 32-bit add that clamps to the representable range
    function automatic logic signed [31:0] sat_add32(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add32 = s[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mpa_round.sv -----
`default_nettype none
// ============================================================================
// mpa_round: round accumulator
// Keeps the best override and base proposals and the saturated correction
// sum; on the last transaction of a round it registers a snapshot and clears.
// ============================================================================
module mpa_round
    import mpa_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_step_valid,
    input  wire t_item  i_item,
    output logic        o_step_stall,
    output logic        o_snap_valid,
    output t_round      o_snap,
    input  wire logic   i_snap_stall
);

    t_round     r_acc;
    t_round     n_acc;
    logic [7:0] r_ovr_prio;
    logic [7:0] n_ovr_prio;
    logic [7:0] r_base_prio;
    logic [7:0] n_base_prio;
    logic       r_snap_valid;
    t_round     r_snap;
    logic       snap_free;
    logic       step_go;

    // handshake toward the input register; only a last item needs snapshot room
    assign snap_free    = !r_snap_valid || !i_snap_stall;
    assign step_go      = i_step_valid && (!i_item.last || snap_free);
    assign o_step_stall = i_step_valid && !step_go;

    // merge one proposal into the round
    always_comb begin
        n_acc       = r_acc;
        n_ovr_prio  = r_ovr_prio;
        n_base_prio = r_base_prio;
        if (i_item.proposal_valid) begin
            unique case (i_item.mode)
                MODE_BASE: begin
                    if (!r_acc.base_present || i_item.prio > r_base_prio) begin
                        n_acc.base_present  = 1'b1;
                        n_acc.base_velocity = i_item.velocity;
                        n_base_prio         = i_item.prio;
                    end
                end
                MODE_CORRECTION: begin
                    n_acc.corr_sum  = sat_add32(r_acc.corr_sum, i_item.velocity);
                    n_acc.corr_seen = 1'b1;
                end
                MODE_OVERRIDE: begin
                    if (!r_acc.ovr_present || i_item.prio > r_ovr_prio) begin
                        n_acc.ovr_present     = 1'b1;
                        n_acc.ovr_is_position = i_item.is_position;
                        n_acc.ovr_velocity    = i_item.velocity;
                        n_acc.ovr_position    = i_item.position;
                        n_acc.ovr_relative    = i_item.relative;
                        n_ovr_prio            = i_item.prio;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // round state, cleared after the last transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_ovr_prio  <= '0;
            r_base_prio <= '0;
        end else if (step_go) begin
            if (i_item.last) begin
                r_acc       <= '0;
                r_ovr_prio  <= '0;
                r_base_prio <= '0;
            end else begin
                r_acc       <= n_acc;
                r_ovr_prio  <= n_ovr_prio;
                r_base_prio <= n_base_prio;
            end
        end
    end

    // snapshot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (step_go && i_item.last) begin
            r_snap_valid <= 1'b1;
        end else begin
            r_snap_valid <= r_snap_valid && i_snap_stall;
        end
    end

    // snapshot payload
    always_ff @(posedge i_clk) begin
        if (step_go && i_item.last) begin
            r_snap <= n_acc;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    // a closing transaction always leaves a snapshot behind
    a_last_makes_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && i_item.last |=> r_snap_valid)
        else $error("last transaction did not produce a snapshot");

    // a closing transaction clears the round
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && i_item.last |=>
            !r_acc.ovr_present && !r_acc.base_present && !r_acc.corr_seen &&
            r_acc.corr_sum == 32'sd0)
        else $error("round state not cleared after last transaction");

    // a pending snapshot is never overwritten
    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && i_snap_stall |=> r_snap_valid && $stable(r_snap))
        else $error("pending snapshot lost or changed");

    // an absent proposal leaves the round untouched
    a_absent_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && !i_item.last && !i_item.proposal_valid |=> $stable(r_acc))
        else $error("absent proposal changed round state");

endmodule
`default_nettype wire

// ----- hw/rtl/mpa_target.sv -----
`default_nettype none
// ============================================================================
// mpa_target: target composer
// Turns a round snapshot into a target and holds it in the result register
// until the downstream side takes it.
// ============================================================================
module mpa_target
    import mpa_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_snap_valid,
    input  wire t_round        i_snap,
    output logic               o_snap_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_target_kind,
    output logic signed [31:0] o_target_velocity,
    output logic signed [31:0] o_target_position,
    output logic               o_target_relative
);

    logic               r_out_valid;
    t_kind              r_kind;
    logic signed [31:0] r_velocity;
    logic signed [31:0] r_position;
    logic               r_relative;
    t_kind              n_kind;
    logic signed [31:0] n_velocity;
    logic signed [31:0] n_position;
    logic               n_relative;
    logic               load;

    assign o_snap_stall = r_out_valid && i_stall;
    assign load         = i_snap_valid && !o_snap_stall;

    // override wins, then base plus corrections (or corrections alone), else no target
    always_comb begin
        n_kind     = KIND_NONE;
        n_velocity = '0;
        n_position = '0;
        n_relative = 1'b0;
        if (i_snap.ovr_present) begin
            n_velocity = i_snap.ovr_velocity;
            if (i_snap.ovr_is_position) begin
                n_kind     = KIND_POSITION;
                n_position = i_snap.ovr_position;
                n_relative = i_snap.ovr_relative;
            end else begin
                n_kind = KIND_VELOCITY;
            end
        end else if (i_snap.base_present || i_snap.corr_seen) begin
            n_kind     = KIND_VELOCITY;
            n_velocity = i_snap.base_present ?
                         sat_add32(i_snap.corr_sum, i_snap.base_velocity) :
                         i_snap.corr_sum;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= n_kind;
            r_velocity <= n_velocity;
            r_position <= n_position;
            r_relative <= n_relative;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_target_kind     = r_kind;
    assign o_target_velocity = r_velocity;
    assign o_target_position = r_position;
    assign o_target_relative = r_relative;

endmodule
`default_nettype wire

// ----- hw/rtl/motion_proposal_arbiter.sv -----
`default_nettype none
// ============================================================================
// motion_proposal_arbiter: per-axis motion proposal arbitration
// Collects one round of proposals and emits one target per round.
// ============================================================================
// Takes one proposal transaction per clock, with no gaps needed between
// rounds. Each proposal passes through an input register and the round
// accumulator (priority compare plus one saturating add). On the last
// transaction of a round it also passes a snapshot register and the result
// register. After the last proposal is accepted, the snapshot register loads
// first and the result register after it, which then makes the target
// valid. Only a closing proposal can wait in the input register, and
// only while both the snapshot and the result register are still held by a
// stalled downstream side. The input port stalls for as long as that lasts.
module motion_proposal_arbiter
    import mpa_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_proposal_valid,
    input  wire logic [1:0]    i_proposal_mode,
    input  wire logic [7:0]    i_proposal_priority,
    input  wire logic          i_proposal_is_position,
    input  wire logic signed [31:0] i_proposal_velocity,
    input  wire logic signed [31:0] i_proposal_position,
    input  wire logic          i_proposal_relative,
    input  wire logic          i_last_source,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_target_kind,
    output logic signed [31:0] o_target_velocity,
    output logic signed [31:0] o_target_position,
    output logic               o_target_relative
);

    logic   r_in_valid;
    t_item  r_in;
    logic   step_stall;
    logic   in_accept;
    logic   snap_valid;
    t_round snap;
    logic   snap_stall;

    // input register handshake
    assign o_stall   = r_in_valid && step_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (!step_stall) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.proposal_valid <= i_proposal_valid;
            r_in.mode           <= i_proposal_mode;
            r_in.prio           <= i_proposal_priority;
            r_in.is_position    <= i_proposal_is_position;
            r_in.velocity       <= i_proposal_velocity;
            r_in.position       <= i_proposal_position;
            r_in.relative       <= i_proposal_relative;
            r_in.last           <= i_last_source;
        end
    end

    // round accumulator
    mpa_round u_round (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_valid (r_in_valid),
        .i_item       (r_in),
        .o_step_stall (step_stall),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_stall (snap_stall)
    );

    // target composer and result register
    mpa_target u_target (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_snap_valid      (snap_valid),
        .i_snap            (snap),
        .o_snap_stall      (snap_stall),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_target_kind     (o_target_kind),
        .o_target_velocity (o_target_velocity),
        .o_target_position (o_target_position),
        .o_target_relative (o_target_relative)
    );

endmodule
`default_nettype wire
